// ===== rtl/crp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CoAP response parser.
// Used by crp_parser, crp_out_fifo and coap_response_parser_top; depends on nothing.
package crp_pkg;

  localparam int unsigned MAX_TOKEN_LENGTH = 8;
  localparam int unsigned FIFO_DEPTH       = 4;
  localparam int unsigned FIFO_AW          = 2;
  localparam int unsigned FIFO_CW          = 3;

  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_TOKEN     = 3'd2;
  localparam logic [2:0] VERDICT_BAD_OPT   = 3'd3;
  localparam logic [2:0] VERDICT_NO_PAYLD  = 3'd4;

  localparam logic [3:0] NIB_EXT1   = 4'd13;
  localparam logic [3:0] NIB_EXT2   = 4'd14;
  localparam logic [3:0] NIB_BAD    = 4'd15;
  localparam logic [7:0] MARKER     = 8'hFF;
  localparam logic [9:0] COUNT_SAT  = 10'd1023;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_TOKEN     = 3'd1,
    PH_OPT_HEAD  = 3'd2,
    PH_DELTA_EXT = 3'd3,
    PH_LEN_EXT   = 3'd4,
    PH_VALUE     = 3'd5,
    PH_PAYLOAD   = 3'd6
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [9:0] status_code;
    logic [2:0] verdict;
    logic [9:0] payload_length;
    logic       run_end;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ===== rtl/coap_response_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the CoAP response parser: byte parser feeding a small result queue.
// Depends on crp_pkg, crp_parser and crp_out_fifo.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | data_byte, last_byte
//   out_    | output    | out_valid/out_stall| kind, payload_byte, status_code,
//           |           |                    | verdict, payload_length, run_end
//
// One byte beat can be taken in every cycle while in_stall is low; its results are queued in the same cycle.
// A byte yields at most two results; the four-entry queue sets in_stall when it
// lacks room for two, so the sustained rate is one byte per cycle while out_stall is low.
// The results of a beat reach the outputs from the registered queue, not from the parser directly.
// Synchronous active-low reset empties the queue and returns the parser to the header.
module coap_response_parser_top import crp_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [9:0] out_status_code,
  output logic [2:0] out_verdict,
  output logic [9:0] out_payload_length,
  output logic       out_run_end
);

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  crp_parser #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .data_byte(in_data_byte),
    .last_byte(in_last_byte),
    .push     (push)
  );

  crp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign out_kind           = head.kind;
  assign out_payload_byte   = head.payload_byte;
  assign out_status_code    = head.status_code;
  assign out_verdict        = head.verdict;
  assign out_payload_length = head.payload_length;
  assign out_run_end        = head.run_end;

endmodule

// ===== rtl/crp_parser.sv =====
`timescale 1ns / 1ps
// Byte-wise parser state and per-beat result formation for the CoAP response parser.
// Depends on crp_pkg for the phase type and the result structures.
module crp_parser import crp_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  localparam int unsigned PW = $clog2(MAX_MESSAGE_BYTES + 1);

  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [3:0]    tl_r, tl_nxt;
  logic [1:0]    ext_r, ext_nxt;
  logic [16:0]   ovl_r, ovl_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [9:0]    del_r, del_nxt;
  logic [2:0]    drop_r, drop_nxt;

  logic          active;
  logic          emit;
  logic [16:0]   bl_src;
  logic [2:0]    verdict;
  logic [2:0]    cls;
  logic [9:0]    status;
  logic [PW-1:0] token_end;
  res_t          pay_res;
  res_t          done_res;

  assign active = (drop_r == 3'd0) && (pos_r < PW'(MAX_MESSAGE_BYTES));
  assign bl_src = (phase_r == PH_OPT_HEAD) ? {13'd0, data_byte[3:0]} : ovl_r;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    code_nxt  = code_r;
    tl_nxt    = tl_r;
    ext_nxt   = ext_r;
    ovl_nxt   = ovl_r;
    hi_nxt    = hi_r;
    del_nxt   = del_r;
    drop_nxt  = drop_r;
    emit      = 1'b0;
    if (accept && active) begin
      pos_nxt = pos_r + PW'(1);
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == PW'(0)) tl_nxt = data_byte[3:0];
          if (pos_r == PW'(1)) code_nxt = data_byte;
          if (pos_r == PW'(3)) begin
            if (32'(tl_r) > MAX_TOKEN_LENGTH) drop_nxt = VERDICT_SHORT;
            else if (tl_r != 4'd0) phase_nxt = PH_TOKEN;
            else phase_nxt = PH_OPT_HEAD;
          end
        end
        PH_TOKEN: begin
          phase_nxt = PH_TOKEN;
        end
        PH_OPT_HEAD: begin
          if (data_byte == MARKER) begin
            phase_nxt = PH_PAYLOAD;
          end else if (data_byte[7:4] == NIB_BAD || data_byte[3:0] == NIB_BAD) begin
            drop_nxt = VERDICT_BAD_OPT;
          end else begin
            ovl_nxt = bl_src;
            if (data_byte[7:4] == NIB_EXT1) begin
              ext_nxt   = 2'd1;
              phase_nxt = PH_DELTA_EXT;
            end else if (data_byte[7:4] == NIB_EXT2) begin
              ext_nxt   = 2'd2;
              phase_nxt = PH_DELTA_EXT;
            end else if (bl_src == 17'd13) begin
              ext_nxt   = 2'd1;
              phase_nxt = PH_LEN_EXT;
            end else if (bl_src == 17'd14) begin
              ext_nxt   = 2'd2;
              phase_nxt = PH_LEN_EXT;
            end else if (bl_src == 17'd0) begin
              phase_nxt = PH_OPT_HEAD;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        PH_DELTA_EXT: begin
          ext_nxt = ext_r - 2'd1;
          if (ext_nxt == 2'd0) begin
            if (bl_src == 17'd13) begin
              ext_nxt   = 2'd1;
              phase_nxt = PH_LEN_EXT;
            end else if (bl_src == 17'd14) begin
              ext_nxt   = 2'd2;
              phase_nxt = PH_LEN_EXT;
            end else if (bl_src == 17'd0) begin
              phase_nxt = PH_OPT_HEAD;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        PH_LEN_EXT: begin
          if (ovl_r == 17'd13) begin
            ovl_nxt   = {9'd0, data_byte} + 17'd13;
            ext_nxt   = 2'd0;
            phase_nxt = PH_VALUE;
          end else if (ext_r == 2'd2) begin
            hi_nxt  = data_byte;
            ext_nxt = 2'd1;
          end else begin
            ovl_nxt   = {1'b0, hi_r, data_byte} + 17'd269;
            ext_nxt   = 2'd0;
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          ovl_nxt = ovl_r - 17'd1;
          if (ovl_nxt == 17'd0) phase_nxt = PH_OPT_HEAD;
        end
        PH_PAYLOAD: begin
          if (del_r < COUNT_SAT) del_nxt = del_r + 10'd1;
          emit = 1'b1;
        end
        default: begin
          drop_nxt = VERDICT_SHORT;
        end
      endcase
    end
  end

  assign token_end = PW'(4) + PW'(tl_nxt);

  always_comb begin
    if (drop_nxt != 3'd0) begin
      verdict = drop_nxt;
    end else begin
      case (phase_nxt)
        PH_HEADER:   verdict = VERDICT_SHORT;
        PH_TOKEN:    verdict = (pos_nxt < token_end) ? VERDICT_SHORT : VERDICT_TOKEN;
        PH_OPT_HEAD: verdict = VERDICT_OK;
        PH_PAYLOAD:  verdict = (del_nxt == 10'd0) ? VERDICT_NO_PAYLD : VERDICT_OK;
        default:     verdict = VERDICT_BAD_OPT;
      endcase
    end
  end

  assign cls    = code_nxt[7:5];
  assign status = {1'b0, cls, 6'd0} + {2'b0, cls, 5'd0} + {5'd0, cls, 2'd0}
                + {5'd0, code_nxt[4:0]};

  always_comb begin
    pay_res                = '0;
    pay_res.kind           = KIND_PAYLOAD;
    pay_res.payload_byte   = data_byte;
    pay_res.run_end        = ~last_byte;
    done_res               = '0;
    done_res.kind          = KIND_COMPLETE;
    done_res.status_code   = status;
    done_res.verdict       = verdict;
    done_res.payload_length = (verdict == VERDICT_OK) ? del_nxt : 10'd0;
    done_res.run_end       = 1'b1;
    push       = '0;
    push.push0 = accept && (emit || last_byte);
    push.push1 = accept && emit && last_byte;
    push.r0    = emit ? pay_res : done_res;
    push.r1    = done_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      code_r  <= '0;
      tl_r    <= '0;
      ext_r   <= '0;
      ovl_r   <= '0;
      hi_r    <= '0;
      del_r   <= '0;
      drop_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      code_r  <= code_nxt;
      tl_r    <= tl_nxt;
      ext_r   <= ext_nxt;
      ovl_r   <= ovl_nxt;
      hi_r    <= hi_nxt;
      del_r   <= del_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // A completed message leaves the parser ready for a fresh header.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> phase_r == PH_HEADER && pos_r == '0 && drop_r == 3'd0)
    else $error("parser state not cleared after final beat");

  // Payload bytes are only ever counted once the marker has been seen.
  a_count_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    del_r != 10'd0 |-> phase_r == PH_PAYLOAD)
    else $error("payload count outside payload phase");

  // A double push is always a payload beat followed by its completion.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0 && push.r0.kind == KIND_PAYLOAD
                   && push.r1.kind == KIND_COMPLETE)
    else $error("bad ordering of paired results");

endmodule

// ===== rtl/crp_out_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue: takes up to two results per cycle and delivers one per beat.
// Depends on crp_pkg for the result structures and queue sizing.
module crp_out_fifo import crp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  head
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_p1;

  assign room      = cnt_r <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_r];
  assign wr_p1     = wr_r + FIFO_AW'(1);

  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
    rd_nxt  = rd_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push.push0) + FIFO_CW'(push.push1) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wr_r] <= push.r0;
    if (push.push1) mem_r[wr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> room)
    else $error("result pushed without room for a pair");

  a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
    FIFO_AW'(wr_r - rd_r) == cnt_r[FIFO_AW-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

// ===== verif/tb_coap_response_parser_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for coap_response_parser_top: directed and random CoAP frames
// are driven byte by byte, and a scoreboard class predicts every result beat.
// Depends on crp_pkg and the parser RTL.
module tb_coap_response_parser_top;
  import crp_pkg::*;

  localparam int unsigned MSG_BYTES = 1024;
  localparam int unsigned RANDOM_BYTES = 210;

  class coap_parse_scoreboard;
    int unsigned msg_cap;
    phase_t      phase;
    logic [10:0] pos;
    logic [7:0]  code;
    logic [3:0]  tlen;
    logic [1:0]  ext_left;
    logic [16:0] opt_left;
    logic [7:0]  len_hi;
    logic [9:0]  count;
    logic [2:0]  drop;
    res_t        expected_q[$];
    int          errors;

    function new(int unsigned cap);
      msg_cap = cap;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_HEADER;
      pos = '0;
      code = '0;
      tlen = '0;
      ext_left = '0;
      opt_left = '0;
      len_hi = '0;
      count = '0;
      drop = VERDICT_OK;
    endfunction

    function void start_length();
      if (opt_left == 17'(NIB_EXT1)) begin
        ext_left = 2'd1;
        phase = PH_LEN_EXT;
      end else if (opt_left == 17'(NIB_EXT2)) begin
        ext_left = 2'd2;
        phase = PH_LEN_EXT;
      end else if (opt_left == 17'd0) begin
        phase = PH_OPT_HEAD;
      end else begin
        phase = PH_VALUE;
      end
    endfunction

    function bit absorb_byte(logic [7:0] b);
      logic [10:0] at;
      logic [3:0]  dn;
      logic [3:0]  ln;
      bit          emit;
      at = pos;
      pos = pos + 11'd1;
      dn = b[7:4];
      ln = b[3:0];
      emit = 1'b0;
      case (phase)
        PH_HEADER: begin
          if (at == 11'd0) tlen = b[3:0];
          if (at == 11'd1) code = b;
          if (at == 11'd3) begin
            if (tlen > MAX_TOKEN_LENGTH) drop = VERDICT_SHORT;
            else if (tlen != 4'd0) phase = PH_TOKEN;
            else phase = PH_OPT_HEAD;
          end
        end
        PH_TOKEN: ;
        PH_OPT_HEAD: begin
          if (b == MARKER) begin
            phase = PH_PAYLOAD;
          end else if (dn == NIB_BAD || ln == NIB_BAD) begin
            drop = VERDICT_BAD_OPT;
          end else begin
            opt_left = 17'(ln);
            if (dn == NIB_EXT1) begin
              ext_left = 2'd1;
              phase = PH_DELTA_EXT;
            end else if (dn == NIB_EXT2) begin
              ext_left = 2'd2;
              phase = PH_DELTA_EXT;
            end else begin
              start_length();
            end
          end
        end
        PH_DELTA_EXT: begin
          ext_left = ext_left - 2'd1;
          if (ext_left == 2'd0) start_length();
        end
        PH_LEN_EXT: begin
          if (opt_left == 17'(NIB_EXT1)) begin
            opt_left = 17'(b) + 17'd13;
            ext_left = 2'd0;
            phase = PH_VALUE;
          end else if (ext_left == 2'd2) begin
            len_hi = b;
            ext_left = 2'd1;
          end else begin
            opt_left = 17'({len_hi, b}) + 17'd269;
            ext_left = 2'd0;
            phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          opt_left = opt_left - 17'd1;
          if (opt_left == 17'd0) phase = PH_OPT_HEAD;
        end
        PH_PAYLOAD: begin
          if (count < COUNT_SAT) count = count + 10'd1;
          emit = 1'b1;
        end
        default: drop = VERDICT_SHORT;
      endcase
      return emit;
    endfunction

    function logic [2:0] verdict_now();
      if (drop != VERDICT_OK) return drop;
      case (phase)
        PH_HEADER:   return VERDICT_SHORT;
        PH_TOKEN:    return (pos < 11'(4 + tlen)) ? VERDICT_SHORT : VERDICT_TOKEN;
        PH_OPT_HEAD: return VERDICT_OK;
        PH_PAYLOAD:  return (count == 10'd0) ? VERDICT_NO_PAYLD : VERDICT_OK;
        default:     return VERDICT_BAD_OPT;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      res_t       r;
      logic [2:0] v;
      if (drop == VERDICT_OK && pos < msg_cap) begin
        if (absorb_byte(b)) begin
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.run_end = !l;
          expected_q.push_back(r);
        end
      end
      if (l) begin
        v = verdict_now();
        r = '0;
        r.kind = KIND_COMPLETE;
        r.status_code = 10'(int'(code[7:5]) * 100 + int'(code[4:0]));
        r.verdict = v;
        r.payload_length = (v == VERDICT_OK) ? count : 10'd0;
        r.run_end = 1'b1;
        expected_q.push_back(r);
        clear();
      end
    endfunction

    function void compare_field(string name, logic [9:0] e, logic [9:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(res_t act);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual kind %0d byte %0d",
                 $time, act.kind, act.payload_byte);
        return;
      end
      e = expected_q.pop_front();
      compare_field("kind", 10'(e.kind), 10'(act.kind));
      compare_field("payload_byte", 10'(e.payload_byte), 10'(act.payload_byte));
      compare_field("status_code", e.status_code, act.status_code);
      compare_field("verdict", 10'(e.verdict), 10'(act.verdict));
      compare_field("payload_length", e.payload_length, act.payload_length);
      compare_field("run_end", 10'(e.run_end), 10'(act.run_end));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic [9:0] out_status_code;
  logic [2:0] out_verdict;
  logic [9:0] out_payload_length;
  logic       out_run_end;

  coap_parse_scoreboard sb = new(MSG_BYTES);
  logic [7:0] frame[$];
  bit         in_idle_on = 1'b0;
  bit         out_idle_on = 1'b0;
  int         bytes_sent = 0;

  coap_response_parser_top #(.MAX_MESSAGE_BYTES(MSG_BYTES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_status_code    (out_status_code),
    .out_verdict        (out_verdict),
    .out_payload_length (out_payload_length),
    .out_run_end        (out_run_end)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_frame();
    in_idle_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic put_header(input logic [3:0] tkl, input logic [7:0] code_val);
    frame = '{{4'h6, tkl}, code_val, 8'h12, 8'h34};
  endtask

  task automatic push_random(input int n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  function automatic logic [3:0] pick_nibble();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if (n == NIB_BAD && $urandom_range(0, 3) != 0) n = 4'($urandom_range(0, 12));
    if (n == NIB_EXT2 && $urandom_range(0, 3) != 0) n = 4'($urandom_range(0, 12));
    return n;
  endfunction

  task automatic make_random_frame();
    int         pick;
    int         tkl;
    int         nopt;
    int         len;
    logic [3:0] dn;
    logic [3:0] ln;
    logic [7:0] ext;
    frame.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_random($urandom_range(1, 12));
      return;
    end
    tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 0;
    put_header(4'(tkl), 8'($urandom));
    frame[0][7:4] = 4'($urandom);
    push_random(tkl);
    nopt = $urandom_range(0, 3);
    repeat (nopt) begin
      dn = pick_nibble();
      ln = pick_nibble();
      frame.push_back({dn, ln});
      if (dn == NIB_EXT1) push_random(1);
      if (dn == NIB_EXT2) push_random(2);
      len = ln;
      if (ln == NIB_EXT1) begin
        ext = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        frame.push_back(ext);
        len = ext + 13;
      end else if (ln == NIB_EXT2) begin
        ext = 8'($urandom_range(0, 15));
        frame.push_back(8'h00);
        frame.push_back(ext);
        len = ext + 269;
      end
      push_random(len);
    end
    if ($urandom_range(0, 3) != 0) begin
      frame.push_back(MARKER);
      push_random($urandom_range(0, 24));
    end
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, frame.size());
      while (frame.size() > len) void'(frame.pop_back());
    end
  endtask

  initial begin
    res_t act;
    int   gap;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) out_idle_on = !out_idle_on;
      gap = out_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      act.kind = out_kind;
      act.payload_byte = out_payload_byte;
      act.status_code = out_status_code;
      act.verdict = out_verdict;
      act.payload_length = out_payload_length;
      act.run_end = out_run_end;
      sb.check_result(act);
    end
  end

  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int start_count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    frame = '{8'h50};
    send_frame();
    frame = '{8'h60, 8'hFF};
    send_frame();
    put_header(4'd0, 8'h45);
    send_frame();
    put_header(4'd15, 8'h00);
    send_frame();
    put_header(4'd9, 8'h44);
    frame.push_back(8'hAA);
    send_frame();
    put_header(4'd8, 8'h45);
    push_random(8);
    send_frame();
    put_header(4'd2, 8'h45);
    frame.push_back(8'h11);
    send_frame();
    put_header(4'd0, 8'h45);
    frame = {frame, 8'hF1, 8'h00, 8'hFF, 8'h33};
    send_frame();
    put_header(4'd0, 8'h84);
    frame = {frame, 8'h1F, 8'hFF, 8'h01};
    send_frame();
    put_header(4'd0, 8'hFF);
    frame.push_back(MARKER);
    send_frame();
    put_header(4'd0, 8'h45);
    frame = {frame, 8'hB1, 8'h61, MARKER, 8'h00, 8'hFF, 8'h80};
    send_frame();
    put_header(4'd0, 8'h45);
    frame = {frame, 8'hDD, 8'h05, 8'h02};
    push_random(15);
    frame = {frame, MARKER, 8'h5A};
    send_frame();
    put_header(4'd0, 8'h45);
    frame = {frame, 8'hEE, 8'h01, 8'h02, 8'h00, 8'h01};
    push_random(270);
    frame = {frame, MARKER, 8'h01, 8'hFE};
    push_random(750);
    send_frame();
    put_header(4'd0, 8'h45);
    frame = {frame, 8'hE1, 8'h00};
    send_frame();
    put_header(4'd0, 8'h45);
    frame.push_back(8'h1D);
    send_frame();
    put_header(4'd0, 8'h45);
    frame = {frame, 8'h13, 8'hAA};
    send_frame();
    put_header(4'd0, 8'hA0);
    frame = {frame, 8'h10, 8'h20};
    send_frame();

    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      make_random_frame();
      send_frame();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== coap_response_parser_top.f =====
rtl/crp_pkg.sv
rtl/crp_parser.sv
rtl/crp_out_fifo.sv
rtl/coap_response_parser_top.sv
verif/tb_coap_response_parser_top.sv
